// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

    localparam int BLOCK_W  = 128;
    localparam int HALF_W   = 64;
    localparam int ROUNDS   = 10;
    localparam int RCNT_W   = 4;
    localparam int PADDR_W  = 4;

    typedef logic [BLOCK_W-1:0] t_block;

    // register indexes (selected by paddr[3])
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] REV_BOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    localparam logic [7:0] RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block sbox_layer(input t_block s, input logic inv);
        t_block o;
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = inv ? REV_BOX[s[127-8*i -: 8]] : FWD_BOX[s[127-8*i -: 8]];
        end
        return o;
    endfunction

    // forward: row r rotates left by r; inverse: right by r
    function automatic t_block row_rotate(input t_block s, input logic inv);
        t_block o;
        int     d;
        o = s;
        d = inv ? 3 : 1;
        for (int c = 0; c < 4; c++) begin
            for (int r = 1; r < 4; r++) begin
                o[127-8*(c*4+r) -: 8] = s[127-8*((((c + d*r) & 3) * 4) + r) -: 8];
            end
        end
        return o;
    endfunction

    function automatic t_block mix_cols(input t_block s);
        t_block     o;
        logic [7:0] p0, p1, p2, p3, t;
        for (int c = 0; c < 4; c++) begin
            p0 = s[127-32*c -: 8];
            p1 = s[119-32*c -: 8];
            p2 = s[111-32*c -: 8];
            p3 = s[103-32*c -: 8];
            t  = p0 ^ p1 ^ p2 ^ p3;
            o[127-32*c -: 8] = p0 ^ t ^ xtime(p0 ^ p1);
            o[119-32*c -: 8] = p1 ^ t ^ xtime(p1 ^ p2);
            o[111-32*c -: 8] = p2 ^ t ^ xtime(p2 ^ p3);
            o[103-32*c -: 8] = p3 ^ t ^ xtime(p3 ^ p0);
        end
        return o;
    endfunction

    // inverse mix = premultiply by {04}x^2+{05}, then forward mix
    function automatic t_block inv_mix_cols(input t_block s);
        t_block     o;
        logic [7:0] u, v;
        for (int c = 0; c < 4; c++) begin
            u = xtime(xtime(s[127-32*c -: 8] ^ s[111-32*c -: 8]));
            v = xtime(xtime(s[119-32*c -: 8] ^ s[103-32*c -: 8]));
            o[127-32*c -: 8] = s[127-32*c -: 8] ^ u;
            o[119-32*c -: 8] = s[119-32*c -: 8] ^ v;
            o[111-32*c -: 8] = s[111-32*c -: 8] ^ u;
            o[103-32*c -: 8] = s[103-32*c -: 8] ^ v;
        end
        return mix_cols(o);
    endfunction

    function automatic t_block key_next(input t_block k, input logic [7:0] rc);
        logic [31:0] w3, t, n0, n1, n2, n3;
        w3 = k[31:0];
        t  = {FWD_BOX[w3[23:16]], FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
        t  = t ^ {rc, 24'h0};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

`default_nettype wire

// ===== design/aes_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, kind, block_high, block_low, input ready);
    modport sink (input valid, kind, block_high, block_low, output ready);
endinterface

`default_nettype wire

// ===== design/aes_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink (input valid, result_high, result_low, output ready);
endinterface

`default_nettype wire

// ===== design/aes128_block_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                          Handshake
// i_blk     in   kind, block_high, block_low      valid/ready
// o_res     out  result_high, result_low          valid/ready
// APB       in   key_high @0x0, key_low @0x8      psel/penable/pwrite, pready=1
//
// One block per cycle unless the output stalls or keys are being expanded; the pipeline
// is a key add stage + ten round stages. After reset and after each key write the
// round keys are expanded, one per cycle; i_blk.ready is low during that time.
// A stalled output freezes the whole pipeline; an input skid register keeps
// i_blk.ready independent of o_res.ready.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    aes_in_if.sink                  i_blk,
    aes_out_if.source               o_res,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [63:0]        i_pwdata,
    output logic [63:0]             o_prdata,
    output logic                    o_pready
);

    logic [HALF_W-1:0] r_key_high, r_key_low;
    logic              r_busy;
    logic [RCNT_W-1:0] r_cnt;
    t_block            r_work;
    t_block            r_rk [1:ROUNDS];
    t_block            w_key0;
    t_block            w_knext;
    logic              w_wr;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[3] == REG_KEY_LOW) ? r_key_low : r_key_high;
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_key0   = {r_key_high, r_key_low};
    assign w_knext  = key_next(r_work, RCON[r_cnt]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_busy     <= 1'b1;
            r_cnt      <= '0;
        end else if (w_wr) begin
            if (i_paddr[3] == REG_KEY_LOW) begin
                r_key_low <= i_pwdata;
            end else begin
                r_key_high <= i_pwdata;
            end
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == RCNT_W'(ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // count 0 loads the key, counts 1..10 produce round keys
    always_ff @(posedge i_clk) begin
        if (r_busy && !w_wr) begin
            if (r_cnt == '0) begin
                r_work <= w_key0;
            end else begin
                r_work       <= w_knext;
                r_rk[r_cnt]  <= w_knext;
            end
        end
    end

    // input skid
    logic   r_skid_v;
    logic   r_skid_kind;
    t_block r_skid_blk;
    logic   w_in_xfer;
    logic   w_en;
    logic   w_src_v;
    logic   w_src_kind;
    t_block w_src_blk;

    logic   r_v    [0:ROUNDS];
    logic   r_kind [0:ROUNDS];
    t_block r_st   [0:ROUNDS];

    assign i_blk.ready = !r_skid_v && !r_busy;
    assign w_in_xfer   = i_blk.valid && i_blk.ready;
    assign w_en        = !r_v[ROUNDS] || o_res.ready;
    assign w_src_v     = r_skid_v || w_in_xfer;
    assign w_src_kind  = r_skid_v ? r_skid_kind : i_blk.kind;
    assign w_src_blk   = r_skid_v ? r_skid_blk : {i_blk.block_high, i_blk.block_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= 1'b0;
        end else if (w_in_xfer) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_xfer) begin
            r_skid_kind <= i_blk.kind;
            r_skid_blk  <= {i_blk.block_high, i_blk.block_low};
        end
    end

    // stage 0: initial key add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= w_src_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind[0] <= w_src_kind;
            r_st[0]   <= w_src_blk ^ ((w_src_kind == KIND_DEC) ? r_rk[ROUNDS] : w_key0);
        end
    end

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        t_block w_enc_key, w_dec_key;
        t_block n_st;
        t_block w_e, w_d;

        assign w_enc_key = r_rk[g];
        if (g == ROUNDS) begin : g_last
            assign w_dec_key = w_key0;
        end else begin : g_mid
            assign w_dec_key = r_rk[ROUNDS-g];
        end

        always_comb begin
            w_e = row_rotate(sbox_layer(r_st[g-1], KIND_ENC), KIND_ENC);
            if (g != ROUNDS) begin
                w_e = mix_cols(w_e);
            end
            w_e = w_e ^ w_enc_key;
            w_d = sbox_layer(row_rotate(r_st[g-1], KIND_DEC), KIND_DEC) ^ w_dec_key;
            if (g != ROUNDS) begin
                w_d = inv_mix_cols(w_d);
            end
            n_st = (r_kind[g-1] == KIND_DEC) ? w_d : w_e;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_en) begin
                r_v[g] <= r_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_kind[g] <= r_kind[g-1];
                r_st[g]   <= n_st;
            end
        end
    end

    assign o_res.valid       = r_v[ROUNDS];
    assign o_res.result_high = r_st[ROUNDS][127:64];
    assign o_res.result_low  = r_st[ROUNDS][63:0];

endmodule

`default_nettype wire
